@@ rtl/core/lba_pkg.sv @@
// Shared constants, codes and types of the linked block allocator.
package lba_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int MAX_FILES  = 16;

   localparam int FILE_ID_W = 4;
   localparam int COUNT_W   = 7;
   localparam int BLOCK_W   = 6;

   localparam int BLK_W   = $clog2(MAX_BLOCKS);
   localparam int FILE_AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

   localparam logic [COUNT_W-1:0] NUM_BLOCKS_RESET = COUNT_W'(64);
   localparam logic [BLK_W-1:0]   LAST_BLOCK       = BLK_W'(MAX_BLOCKS - 1);

   localparam logic MODE_CREATE = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_SLOT_USED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RECOUNT,
      S_CHECK,
      S_DIR_READ,
      S_ALLOC,
      S_WALK,
      S_REPLY
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [BLOCK_W-1:0] block_number;
      logic              block_valid;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } push_type;

   typedef struct packed {
      logic               recount;
      logic               out_free;
      logic [COUNT_W-1:0] active_n;
   } ctl_type;

   typedef struct packed {
      logic [BLK_W-1:0]   head;
      logic [COUNT_W-1:0] size;
   } dir_type;

endpackage

@@ rtl/core/lba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/lba_seq.sv @@
// Request sequencer: bitmap scan, chain walk, directory and free count upkeep.
module lba_seq import lba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [FILE_ID_W-1:0] req_file_id,
   input  logic [COUNT_W-1:0]   req_block_count,
   input  ctl_type              ctl,
   output push_type             push
);

   state_type                state_ff, state_in;
   logic [MAX_BLOCKS-1:0]    used_ff, used_in;
   logic [MAX_FILES-1:0]     slot_valid_ff, slot_valid_in;
   logic [COUNT_W-1:0]       free_ff, free_in;
   logic                     have_prev_ff, have_prev_in;
   logic                     use_link_ff, use_link_in;

   logic [BLK_W-1:0]         idx_ff, idx_in;
   logic [BLK_W-1:0]         prev_ff, prev_in;
   logic [BLK_W-1:0]         cur_ff, cur_in;
   logic [COUNT_W-1:0]       left_ff, left_in;
   logic [COUNT_W-1:0]       tally_ff, tally_in;
   logic [COUNT_W-1:0]       want_ff, want_in;
   logic                     mode_ff, mode_in;
   logic [FILE_ID_W-1:0]     fid_ff, fid_in;
   status_type               status_ff, status_in;

   logic                     dir_we;
   dir_type                  dir_wdata;
   dir_type                  dir_rdata;
   logic                     link_we;
   logic [BLK_W-1:0]         link_rdata;
   logic [BLK_W-1:0]         cur_sel;
   logic                     free_here;
   logic                     fid_ok;
   logic [FILE_AW-1:0]       slot_idx;

   lba_ram #(.WIDTH($bits(dir_type)), .DEPTH(MAX_FILES)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (slot_idx),
      .wdata (dir_wdata),
      .raddr (slot_idx),
      .rdata (dir_rdata)
   );

   lba_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (prev_ff),
      .wdata (idx_ff),
      .raddr (cur_sel),
      .rdata (link_rdata)
   );

   always_comb begin
      cur_sel   = use_link_ff ? link_rdata : cur_ff;
      free_here = (COUNT_W'(idx_ff) < ctl.active_n) && !used_ff[idx_ff];
      slot_idx  = FILE_AW'(fid_ff);
      fid_ok    = (32'(fid_ff) < 32'(MAX_FILES));
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      slot_valid_in = slot_valid_ff;
      free_in       = free_ff;
      have_prev_in  = have_prev_ff;
      use_link_in   = use_link_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      tally_in      = tally_ff;
      want_in       = want_ff;
      mode_in       = mode_ff;
      fid_in        = fid_ff;
      status_in     = status_ff;
      req_ready     = 1'b0;
      push          = '0;
      dir_we        = 1'b0;
      dir_wdata     = '0;
      link_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               fid_in   = req_file_id;
               want_in  = req_block_count;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_OK;
            if (!fid_ok) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_REPLY;
            end else if (mode_ff == MODE_CREATE) begin
               if (slot_valid_ff[slot_idx]) begin
                  status_in = ST_SLOT_USED;
                  state_in  = S_REPLY;
               end else if (want_ff > free_ff) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_REPLY;
               end else begin
                  slot_valid_in[slot_idx] = 1'b1;
                  free_in = free_ff - want_ff;
                  if (want_ff == '0) begin
                     dir_we   = 1'b1;
                     state_in = S_REPLY;
                  end else begin
                     idx_in       = '0;
                     left_in      = want_ff;
                     have_prev_in = 1'b0;
                     state_in     = S_ALLOC;
                  end
               end
            end else begin
               if (!slot_valid_ff[slot_idx]) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_REPLY;
               end else begin
                  slot_valid_in[slot_idx] = 1'b0;
                  state_in = S_DIR_READ;
               end
            end
         end
         S_DIR_READ: begin
            if (dir_rdata.size == '0) begin
               status_in = ST_OK;
               state_in  = S_REPLY;
            end else begin
               left_in     = dir_rdata.size;
               cur_in      = dir_rdata.head;
               use_link_in = 1'b0;
               state_in    = S_WALK;
            end
         end
         S_ALLOC: begin
            if (free_here) begin
               if (ctl.out_free) begin
                  push.valid             = 1'b1;
                  push.word.status       = ST_OK;
                  push.word.block_number = BLOCK_W'(idx_ff);
                  push.word.block_valid  = 1'b1;
                  push.word.last         = (left_ff == COUNT_W'(1));
                  used_in[idx_ff]        = 1'b1;
                  if (have_prev_ff) begin
                     link_we = 1'b1;
                  end else begin
                     dir_we         = 1'b1;
                     dir_wdata.head = idx_ff;
                     dir_wdata.size = want_ff;
                  end
                  prev_in      = idx_ff;
                  have_prev_in = 1'b1;
                  left_in      = left_ff - COUNT_W'(1);
                  idx_in       = idx_ff + BLK_W'(1);
                  if (left_ff == COUNT_W'(1)) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + BLK_W'(1);
            end
         end
         S_WALK: begin
            if (ctl.out_free) begin
               push.valid             = 1'b1;
               push.word.status       = ST_OK;
               push.word.block_number = BLOCK_W'(cur_sel);
               push.word.block_valid  = 1'b1;
               push.word.last         = (left_ff == COUNT_W'(1));
               used_in[cur_sel]       = 1'b0;
               if (COUNT_W'(cur_sel) < ctl.active_n) begin
                  free_in = free_ff + COUNT_W'(1);
               end
               left_in     = left_ff - COUNT_W'(1);
               use_link_in = 1'b1;
               if (left_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end else begin
               cur_in      = cur_sel;
               use_link_in = 1'b0;
            end
         end
         S_REPLY: begin
            if (ctl.out_free) begin
               push.valid       = 1'b1;
               push.word.status = status_ff;
               push.word.last   = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_RECOUNT: begin
            tally_in = tally_ff + COUNT_W'(free_here);
            idx_in   = idx_ff + BLK_W'(1);
            if (idx_ff == LAST_BLOCK) begin
               free_in  = tally_ff + COUNT_W'(free_here);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ctl.recount) begin
         state_in = S_RECOUNT;
         idx_in   = '0;
         tally_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         slot_valid_ff <= '0;
         free_ff       <= COUNT_W'(MAX_BLOCKS);
         have_prev_ff  <= 1'b0;
         use_link_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         slot_valid_ff <= slot_valid_in;
         free_ff       <= free_in;
         have_prev_ff  <= have_prev_in;
         use_link_ff   <= use_link_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      left_ff   <= left_in;
      tally_ff  <= tally_in;
      want_ff   <= want_in;
      mode_ff   <= mode_in;
      fid_ff    <= fid_in;
      status_ff <= status_in;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> ctl.out_free)
      else $error("Result word pushed while the output register is full.");

   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.word.last && !ctl.recount) |=> (state_ff == S_IDLE))
      else $error("Sequencer did not return to idle after the final word.");

   a_alloc_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> (left_ff != '0))
      else $error("Allocation scan running with no blocks left to take.");

endmodule

@@ rtl/core/linked_block_allocator_core.sv @@
// Linked block allocator: a free bitmap, a link table and a 16-slot file directory.
// A request word on the req_ channel creates a file (mode 0) of block_count blocks
// in slot file_id or deletes the file in that slot (mode 1). Each request yields
// one or more words on the rsp_ channel; the final word of a request has last set.
// A create takes the lowest-numbered free blocks in order and returns one word per
// block; a delete walks the chain from its head and returns one word per freed
// block. A failed request or a zero-size file returns a single status word.
// An accepted request moves from S_IDLE to S_CHECK. A create then scans the
// bitmap one block per cycle, pausing on a free block while the output
// register is full; a delete does one link table read per block. The
// sequencer handles one request at a time and req_ready is high only while
// it is idle.
// Results pass through one output register. The sequencer pushes a word only
// when that register is empty or is read in the same cycle, so while rsp_ready
// stays low with a word waiting the sequencer does not push its next word.
// A write of csr_write_data (num_blocks) starts a recount of free blocks,
// during which req_ready is low.
// After reset all blocks are free, no files exist and num_blocks is 64.
module linked_block_allocator_core import lba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [FILE_ID_W-1:0] req_file_id,
   input  logic [COUNT_W-1:0]   req_block_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [BLOCK_W-1:0]   rsp_block_number,
   output logic                 rsp_block_valid,
   output logic                 rsp_last,
   input  logic                 csr_write_en,
   input  logic [COUNT_W-1:0]   csr_write_data
);

   logic [COUNT_W-1:0] num_blocks_ff;
   logic [COUNT_W-1:0] active_n;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   ctl_type            ctl;
   push_type           push;

   lba_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_file_id     (req_file_id),
      .req_block_count (req_block_count),
      .ctl             (ctl),
      .push            (push)
   );

   always_comb begin
      if (num_blocks_ff == '0) begin
         active_n = COUNT_W'(1);
      end else if (num_blocks_ff > COUNT_W'(MAX_BLOCKS)) begin
         active_n = COUNT_W'(MAX_BLOCKS);
      end else begin
         active_n = num_blocks_ff;
      end
      ctl.recount  = csr_write_en;
      ctl.out_free = !rsp_valid_ff || rsp_ready;
      ctl.active_n = active_n;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = push.word;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_word_in  = rsp_word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blocks_ff <= NUM_BLOCKS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            num_blocks_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_word_ff.status;
   assign rsp_block_number = rsp_word_ff.block_number;
   assign rsp_block_valid  = rsp_word_ff.block_valid;
   assign rsp_last         = rsp_word_ff.last;

endmodule
